FILE: rtl/skt_pkg.sv
package skt_pkg;

	localparam int DEFAULT_TABLE_DEPTH = 16;

	localparam int OP_W     = 2;
	localparam int KEY_W    = 32;
	localparam int PAY_W    = 31;
	localparam int POS_W    = 4;
	localparam int STATUS_W = 2;
	localparam int EIDX_W   = 4;
	localparam int ECNT_W   = 5;

	localparam int S_TDATA_W = 72;
	localparam int M_TDATA_W = 80;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_SEARCH = 2'd1,
		OP_DELETE = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_BEYOND    = 2'd3
	} status_t;

	typedef struct packed {
		logic load;
		logic commit;
	} cmd_t;

endpackage

FILE: rtl/sorted_key_table.sv
// sorted key table: holds up to TABLE_DEPTH records (signed 32-bit key, 31-bit payload) in
// ascending key order, duplicates kept in arrival order. in the cycle a request is accepted
// every cell compares its key with the request key in parallel and the outcome is registered;
// then, once the output register is free, the cells shift (insert opens a gap, delete closes
// one) and the result is registered. a new request is taken once the result has moved into
// the output register; no new request is taken while one is in progress. status codes: 0 ok,
// 1 key not found, 2 table full, 3 position beyond count. entry_index and entry_count carry
// the low 4 and 5 bits of the slot and count.
module sorted_key_table #(
	parameter int TABLE_DEPTH = skt_pkg::DEFAULT_TABLE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// operation[1:0], key[33:2], payload[64:34], position[68:65]
	input  logic [skt_pkg::S_TDATA_W-1:0] s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// status[1:0], found_key[33:2], found_payload[64:34], entry_index[68:65],
	// entry_count[73:69]
	output logic [skt_pkg::M_TDATA_W-1:0] m_tdata
);
	import skt_pkg::*;

	cmd_t cmd;

	skt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	skt_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.s_tdata (s_tdata),
		.m_tdata (m_tdata)
	);

endmodule

FILE: rtl/skt_ctrl.sv
module skt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  logic          m_tready,
	output skt_pkg::cmd_t cmd
);
	import skt_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q;
	logic   out_vld_q;
	logic   commit;

	assign s_tready   = (state_q == S_IDLE);
	assign commit     = (state_q == S_EXEC) && (!out_vld_q || m_tready);
	assign cmd.load   = s_tvalid && s_tready;
	assign cmd.commit = commit;
	assign m_tvalid   = out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (commit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (commit) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/skt_datapath.sv
module skt_datapath #(
	parameter int TABLE_DEPTH = skt_pkg::DEFAULT_TABLE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  skt_pkg::cmd_t                  cmd,
	input  logic [skt_pkg::S_TDATA_W-1:0]  s_tdata,
	output logic [skt_pkg::M_TDATA_W-1:0]  m_tdata
);
	import skt_pkg::*;

	localparam int IDXW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNTW = $clog2(TABLE_DEPTH + 1);

	logic [OP_W-1:0]  in_op;
	logic [KEY_W-1:0] in_key;
	logic [PAY_W-1:0] in_pay;
	logic [POS_W-1:0] in_pos;

	assign in_op  = s_tdata[OP_W-1:0];
	assign in_key = s_tdata[OP_W+KEY_W-1:OP_W];
	assign in_pay = s_tdata[OP_W+KEY_W+PAY_W-1:OP_W+KEY_W];
	assign in_pos = s_tdata[OP_W+KEY_W+PAY_W+POS_W-1:OP_W+KEY_W+PAY_W];

	// table cells
	logic [KEY_W-1:0] key_q [TABLE_DEPTH];
	logic [PAY_W-1:0] pay_q [TABLE_DEPTH];
	logic [CNTW-1:0]  count_q;

	// compare stage
	op_t                    op_s1;
	logic [KEY_W-1:0]       key_s1;
	logic [PAY_W-1:0]       pay_s1;
	logic [TABLE_DEPTH-1:0] le_s1;
	logic [TABLE_DEPTH-1:0] lt_s1;
	logic [TABLE_DEPTH-1:0] ins_oh_s1;
	logic [TABLE_DEPTH-1:0] sel_oh_s1;
	logic                   full_s1;

	logic [TABLE_DEPTH-1:0] vld;
	logic [TABLE_DEPTH-1:0] le;
	logic [TABLE_DEPTH-1:0] lt;
	logic [TABLE_DEPTH-1:0] eq;
	logic [TABLE_DEPTH-1:0] ins_oh;
	logic [TABLE_DEPTH-1:0] fnd_oh;
	logic [TABLE_DEPTH-1:0] rd_oh;

	always_comb begin
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			vld[i] = (CNTW'(i) < count_q);
			le[i]  = vld[i] && ($signed(key_q[i]) <= $signed(in_key));
			lt[i]  = vld[i] && ($signed(key_q[i]) < $signed(in_key));
			eq[i]  = vld[i] && (key_q[i] == in_key);
			rd_oh[i] = vld[i] && (int'(in_pos) == i);
		end
		ins_oh[0] = !le[0];
		fnd_oh[0] = !lt[0] && eq[0];
		for (int i = 1; i < TABLE_DEPTH; i++) begin
			ins_oh[i] = le[i-1] && !le[i];
			fnd_oh[i] = lt[i-1] && !lt[i] && eq[i];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_s1     <= op_t'(in_op);
			key_s1    <= in_key;
			pay_s1    <= in_pay;
			le_s1     <= le;
			lt_s1     <= lt;
			ins_oh_s1 <= ins_oh;
			full_s1   <= (count_q == CNTW'(TABLE_DEPTH));
			unique case (op_t'(in_op))
				OP_INSERT: sel_oh_s1 <= '0;
				OP_READ:   sel_oh_s1 <= rd_oh;
				default:   sel_oh_s1 <= fnd_oh;
			endcase
		end
	end

	// shift stage: encode, select and move cells
	logic [TABLE_DEPTH-1:0] idx_oh;
	logic [IDXW-1:0]        idx;
	logic [KEY_W-1:0]       sel_key;
	logic [PAY_W-1:0]       sel_pay;
	logic                   hit;
	logic                   do_ins;
	logic                   do_del;
	logic [CNTW-1:0]        count_nxt;
	status_t                status;

	assign idx_oh = (op_s1 == OP_INSERT && !full_s1) ? ins_oh_s1 : sel_oh_s1;
	assign hit    = |sel_oh_s1;
	assign do_ins = (op_s1 == OP_INSERT) && !full_s1;
	assign do_del = (op_s1 == OP_DELETE) && hit;

	always_comb begin
		idx     = '0;
		sel_key = '0;
		sel_pay = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			idx     = idx | (idx_oh[i] ? IDXW'(i) : '0);
			sel_key = sel_key | (sel_oh_s1[i] ? key_q[i] : '0);
			sel_pay = sel_pay | (sel_oh_s1[i] ? pay_q[i] : '0);
		end
	end

	always_comb begin
		count_nxt = count_q;
		if (do_ins) begin
			count_nxt = count_q + CNTW'(1);
		end else if (do_del) begin
			count_nxt = count_q - CNTW'(1);
		end
	end

	always_comb begin
		unique case (op_s1)
			OP_INSERT: status = full_s1 ? ST_FULL : ST_OK;
			OP_READ:   status = hit ? ST_OK : ST_BEYOND;
			default:   status = hit ? ST_OK : ST_NOT_FOUND;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				if (do_ins && !le_s1[i]) begin
					if (ins_oh_s1[i] || i == 0) begin
						key_q[i] <= key_s1;
						pay_q[i] <= pay_s1;
					end else begin
						key_q[i] <= key_q[(i > 0) ? i - 1 : 0];
						pay_q[i] <= pay_q[(i > 0) ? i - 1 : 0];
					end
				end else if (do_del && !lt_s1[i] && i < TABLE_DEPTH - 1) begin
					key_q[i] <= key_q[(i < TABLE_DEPTH - 1) ? i + 1 : i];
					pay_q[i] <= pay_q[(i < TABLE_DEPTH - 1) ? i + 1 : i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.commit) begin
			count_q <= count_nxt;
		end
	end

	// result register
	logic [31:0]         idx_w;
	logic [31:0]         cnt_w;
	logic [STATUS_W-1:0] res_status_q;
	logic [KEY_W-1:0]    res_key_q;
	logic [PAY_W-1:0]    res_pay_q;
	logic [EIDX_W-1:0]   res_idx_q;
	logic [ECNT_W-1:0]   res_cnt_q;

	assign idx_w = 32'(idx);
	assign cnt_w = 32'(count_nxt);

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			res_status_q <= status;
			res_key_q    <= sel_key;
			res_pay_q    <= sel_pay;
			res_idx_q    <= idx_w[EIDX_W-1:0];
			res_cnt_q    <= cnt_w[ECNT_W-1:0];
		end
	end

	assign m_tdata = {
		(M_TDATA_W - (STATUS_W + KEY_W + PAY_W + EIDX_W + ECNT_W))'(0),
		res_cnt_q, res_idx_q, res_pay_q, res_key_q, res_status_q
	};

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import skt_pkg::*;

	localparam int DEPTH = DEFAULT_TABLE_DEPTH;
	localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
	localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};
	localparam logic [PAY_W-1:0] PAY_MAX = '1;

	typedef struct {
		op_t                     op;
		logic signed [KEY_W-1:0] key;
		logic [PAY_W-1:0]        payload;
		logic [POS_W-1:0]        position;
	} table_req_t;

	typedef struct {
		status_t                 status;
		logic signed [KEY_W-1:0] found_key;
		logic [PAY_W-1:0]        found_payload;
		logic [EIDX_W-1:0]       entry_index;
		logic [ECNT_W-1:0]       entry_count;
	} table_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;

	table_req_t pending_requests[$];
	table_result_t expected_results[$];
	table_req_t held_request;

	logic signed [KEY_W-1:0] key_tab[DEPTH];
	logic [PAY_W-1:0] pay_tab[DEPTH];
	int tab_count = 0;

	logic signed [KEY_W-1:0] key_pool[6];
	int sender_idle_pct = 0;
	int rx_stall_pct = 0;
	int error_count = 0;

	sorted_key_table #(.TABLE_DEPTH(DEPTH)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #10 clk = ~clk;

	function automatic table_result_t predict_table(input table_req_t r);
		table_result_t res;
		int slot;
		int i;
		bit hit;
		res.status = ST_OK;
		res.found_key = '0;
		res.found_payload = '0;
		res.entry_index = '0;
		case (r.op)
			OP_INSERT: begin
				if (tab_count >= DEPTH) begin
					res.status = ST_FULL;
				end else begin
					slot = 0;
					while (slot < tab_count && key_tab[slot] <= r.key)
						slot++;
					for (i = tab_count; i > slot; i--) begin
						key_tab[i] = key_tab[i-1];
						pay_tab[i] = pay_tab[i-1];
					end
					key_tab[slot] = r.key;
					pay_tab[slot] = r.payload;
					tab_count++;
					res.entry_index = slot[EIDX_W-1:0];
				end
			end
			OP_READ: begin
				if (int'(r.position) >= tab_count) begin
					res.status = ST_BEYOND;
				end else begin
					res.found_key = key_tab[r.position];
					res.found_payload = pay_tab[r.position];
					res.entry_index = r.position;
				end
			end
			default: begin
				hit = 1'b0;
				slot = 0;
				for (i = 0; i < tab_count && !hit; i++) begin
					if (key_tab[i] == r.key) begin
						hit = 1'b1;
						slot = i;
					end
				end
				if (!hit) begin
					res.status = ST_NOT_FOUND;
				end else begin
					res.found_key = key_tab[slot];
					res.found_payload = pay_tab[slot];
					res.entry_index = slot[EIDX_W-1:0];
					if (r.op == OP_DELETE) begin
						for (i = slot; i + 1 < tab_count; i++) begin
							key_tab[i] = key_tab[i+1];
							pay_tab[i] = pay_tab[i+1];
						end
						tab_count--;
					end
				end
			end
		endcase
		res.entry_count = tab_count[ECNT_W-1:0];
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [KEY_W-1:0] want,
			input logic [KEY_W-1:0] got);
		error_count++;
		if (error_count <= 100)
			$display("mismatch %s: expected %h, got %h", what, want, got);
	endtask

	task automatic queue_request(input op_t op, input logic signed [KEY_W-1:0] key,
			input logic [PAY_W-1:0] payload, input logic [POS_W-1:0] position);
		table_req_t r;
		r.op = op;
		r.key = key;
		r.payload = payload;
		r.position = position;
		pending_requests.push_back(r);
	endtask

	function automatic logic signed [KEY_W-1:0] draw_key();
		if ($urandom_range(99) < 15)
			return $urandom;
		return key_pool[$urandom_range(5)];
	endfunction

	task automatic wait_drained();
		while (pending_requests.size() != 0 || expected_results.size() != 0 || s_tvalid)
			@(negedge clk);
	endtask

	// request side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready)
				expected_results.push_back(predict_table(held_request));
			if (!s_tvalid || s_tready) begin
				if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					held_request = pending_requests.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {3'b000, held_request.position, held_request.payload,
						held_request.key, held_request.op};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result side
	always @(posedge clk or negedge arst_n) begin
		table_result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result", '0, m_tdata[KEY_W-1:0]);
				end else begin
					want = expected_results.pop_front();
					if (m_tdata[1:0] !== want.status)
						report_mismatch("status", KEY_W'(want.status), KEY_W'(m_tdata[1:0]));
					if (m_tdata[33:2] !== want.found_key)
						report_mismatch("found_key", want.found_key, m_tdata[33:2]);
					if (m_tdata[64:34] !== want.found_payload)
						report_mismatch("found_payload", KEY_W'(want.found_payload),
							KEY_W'(m_tdata[64:34]));
					if (m_tdata[68:65] !== want.entry_index)
						report_mismatch("entry_index", KEY_W'(want.entry_index),
							KEY_W'(m_tdata[68:65]));
					if (m_tdata[73:69] !== want.entry_count)
						report_mismatch("entry_count", KEY_W'(want.entry_count),
							KEY_W'(m_tdata[73:69]));
				end
			end
			m_tready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	initial begin
		int issued;
		int blk_len;
		int mode;
		int w;
		int k;
		op_t op;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int round = 0; round < 2; round++) begin
			for (int phase = 0; phase < 4; phase++) begin
				case (phase)
					0: begin sender_idle_pct = 0; rx_stall_pct = 0; end
					1: begin sender_idle_pct = 48; rx_stall_pct = 0; end
					2: begin sender_idle_pct = 0; rx_stall_pct = 48; end
					default: begin sender_idle_pct = 17; rx_stall_pct = 17; end
				endcase
				if (round == 0 && phase == 0) begin
					// empty table
					queue_request(OP_READ, '0, '0, '0);
					queue_request(OP_SEARCH, '0, '0, '0);
					queue_request(OP_DELETE, KEY_MIN, '0, '0);
					// extremes and a duplicate key
					queue_request(OP_INSERT, KEY_MAX, '0, '0);
					queue_request(OP_INSERT, KEY_MIN, PAY_MAX, '0);
					queue_request(OP_INSERT, '0, 31'd1, '0);
					queue_request(OP_INSERT, '0, 31'd2, '0);
					queue_request(OP_INSERT, -32'sd1, 31'h5555_5555, '0);
					queue_request(OP_SEARCH, '0, '0, '0);
					queue_request(OP_READ, '0, '0, 4'd3);
					queue_request(OP_READ, '0, '0, 4'd15);
					queue_request(OP_DELETE, '0, '0, '0);
					// fill up, then overflow
					for (k = 0; k < 12; k++)
						queue_request(OP_INSERT, $urandom, PAY_W'($urandom), '0);
					queue_request(OP_INSERT, 32'sd7, PAY_MAX, '0);
					queue_request(OP_READ, '0, '0, 4'd15);
					queue_request(OP_DELETE, KEY_MAX, '0, '0);
					queue_request(OP_SEARCH, KEY_MIN, '0, '0);
				end
				issued = 0;
				while (issued < 156) begin
					for (k = 0; k < 6; k++) begin
						w = $urandom_range(9);
						if (w < 5)
							key_pool[k] = $signed($urandom_range(8)) - 4;
						else if (w == 5)
							key_pool[k] = KEY_MIN;
						else if (w == 6)
							key_pool[k] = KEY_MAX;
						else
							key_pool[k] = $urandom;
					end
					mode = $urandom_range(2);
					blk_len = $urandom_range(40, 8);
					for (k = 0; k < blk_len && issued < 156; k++) begin
						w = $urandom_range(99);
						case (mode)
							0: op = w < 55 ? OP_INSERT : w < 70 ? OP_SEARCH : w < 80 ? OP_DELETE : OP_READ;
							1: op = w < 12 ? OP_INSERT : w < 27 ? OP_SEARCH : w < 75 ? OP_DELETE : OP_READ;
							default: op = w < 30 ? OP_INSERT : w < 55 ? OP_SEARCH : w < 75 ? OP_DELETE : OP_READ;
						endcase
						queue_request(op, draw_key(), PAY_W'($urandom),
							POS_W'($urandom_range(15)));
						issued++;
					end
				end
				wait_drained();
			end
		end

		sender_idle_pct = 0;
		rx_stall_pct = 0;
		wait_drained();
		repeat (10) @(negedge clk);
		if (error_count == 0 && expected_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#5000000;
		$display("status: fail");
		$finish;
	end

endmodule

FILE: sim.f
rtl/skt_pkg.sv
rtl/skt_ctrl.sv
rtl/skt_datapath.sv
rtl/sorted_key_table.sv
verif/tb_top.sv
